// ===== hdl/segment_box_intersection_test_defines.svh =====
// ============================================================================
// Assertion macros for the segment against box intersection test.
// Each macro expands to one labeled concurrent assertion.
// ============================================================================
`ifndef SEGMENT_BOX_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_BOX_INTERSECTION_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define SBIT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbit assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define SBIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbit assertion failed");

// The consequent must hold in the cycle after the antecedent, also during reset.
`define SBIT_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sbit assertion failed");

`endif

// ===== hdl/sbit_pkg.sv =====
// ============================================================================
// sbit_pkg
// Shared widths, types and helper functions of the segment box test.
// ============================================================================
`timescale 1ns / 1ps

package sbit_pkg;

    localparam int CW = 32;
    localparam int NL = 12;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [NL-1:0][2*CW-1:0] t_prods;
    typedef logic [NL-1:0][CW-1:0] t_lanes;

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][CW-1:0] lo;
        logic [2:0][CW-1:0] hi;
        logic [5:0] strad;
        logic [NL-1:0] neg;
        logic reject;
        logic start_in;
    } t_side;

    // Returns the j-th of the two axes other than ax.
    function automatic int oth(input int ax, input int j);
        int r;
        r = 0;
        case (ax)
            0: r = (j == 0) ? 1 : 2;
            1: r = (j == 0) ? 0 : 2;
            default: r = (j == 0) ? 0 : 1;
        endcase
        return r;
    endfunction

    function automatic logic [CW-1:0] mag(input logic signed [CW:0] x);
        logic signed [CW:0] t;
        t = x[CW] ? -x : x;
        return t[CW-1:0];
    endfunction

    function automatic logic signed [CW:0] sext(input logic [CW-1:0] x);
        return $signed({x[CW-1], x});
    endfunction

endpackage

// ===== hdl/sbit_ifs.sv =====
// ============================================================================
// sbit_in_if, sbit_out_if
// Valid/ready channels for query words and result words.
// ============================================================================
`timescale 1ns / 1ps

interface sbit_in_if;
    logic valid;
    logic ready;
    logic signed [sbit_pkg::CW-1:0] start_x, start_y, start_z;
    logic signed [sbit_pkg::CW-1:0] end_x, end_y, end_z;
    logic signed [sbit_pkg::CW-1:0] box_lo_x, box_lo_y, box_lo_z;
    logic signed [sbit_pkg::CW-1:0] box_hi_x, box_hi_y, box_hi_z;
    modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
        box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z, input ready);
    modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
        box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z, output ready);
endinterface

interface sbit_out_if;
    logic valid;
    logic ready;
    logic hit;
    modport source(output valid, hit, input ready);
    modport sink(input valid, hit, output ready);
endinterface

// ===== hdl/sbit_front.sv =====
// ============================================================================
// sbit_front
// Plane distances, straddle and early tests, then the twelve products.
// ============================================================================
`timescale 1ns / 1ps

module sbit_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    sbit_in_if.sink              i_in_word,
    output logic                 o_valid,
    output sbit_pkg::t_prods     o_prod,
    output sbit_pkg::t_lanes     o_div,
    output sbit_pkg::t_side      o_side
);
    localparam int CW = sbit_pkg::CW;
    localparam int NL = sbit_pkg::NL;

    logic [2:0][CW-1:0] s, e, lo, hi;
    logic signed [CW:0] diff [3];
    logic signed [CW:0] d1 [6];
    logic signed [CW:0] d2 [6];
    sbit_pkg::t_side n_side;
    logic [2:0][CW-1:0] n_amag;
    logic [5:0][CW-1:0] n_d1mag;

    logic                r_va, r_vb;
    sbit_pkg::t_side     r_side_a, r_side_b;
    logic [2:0][CW-1:0]  r_amag;
    logic [5:0][CW-1:0]  r_d1mag;
    sbit_pkg::t_prods    r_prod;
    sbit_pkg::t_lanes    r_div;

    assign s  = {i_in_word.start_z, i_in_word.start_y, i_in_word.start_x};
    assign e  = {i_in_word.end_z, i_in_word.end_y, i_in_word.end_x};
    assign lo = {i_in_word.box_lo_z, i_in_word.box_lo_y, i_in_word.box_lo_x};
    assign hi = {i_in_word.box_hi_z, i_in_word.box_hi_y, i_in_word.box_hi_x};

    always_comb begin
        n_side.s = s;
        n_side.lo = lo;
        n_side.hi = hi;
        n_side.reject = 1'b0;
        n_side.start_in = 1'b1;
        for (int k = 0; k < 3; k++) begin
            diff[k] = sbit_pkg::sext(e[k]) - sbit_pkg::sext(s[k]);
            n_amag[k] = sbit_pkg::mag(diff[k]);
            if ((sbit_pkg::sext(e[k]) < sbit_pkg::sext(lo[k]) &&
                 sbit_pkg::sext(s[k]) < sbit_pkg::sext(lo[k])) ||
                (sbit_pkg::sext(e[k]) > sbit_pkg::sext(hi[k]) &&
                 sbit_pkg::sext(s[k]) > sbit_pkg::sext(hi[k]))) begin
                n_side.reject = 1'b1;
            end
            if (!(sbit_pkg::sext(s[k]) > sbit_pkg::sext(lo[k]) &&
                  sbit_pkg::sext(s[k]) < sbit_pkg::sext(hi[k]))) begin
                n_side.start_in = 1'b0;
            end
        end
        for (int f = 0; f < 6; f++) begin
            d1[f] = sbit_pkg::sext(s[f % 3]) -
                    sbit_pkg::sext((f < 3) ? lo[f % 3] : hi[f % 3]);
            d2[f] = sbit_pkg::sext(e[f % 3]) -
                    sbit_pkg::sext((f < 3) ? lo[f % 3] : hi[f % 3]);
            n_d1mag[f] = sbit_pkg::mag(d1[f]);
            n_side.strad[f] = (d1[f] < 0 && d2[f] > 0) || (d1[f] > 0 && d2[f] < 0);
        end
        for (int l = 0; l < NL; l++) begin
            n_side.neg[l] = diff[sbit_pkg::oth((l / 2) % 3, l % 2)][CW] ^
                            (d1[l / 2] > 0) ^ diff[(l / 2) % 3][CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_in_word.valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_a <= n_side;
            r_amag <= n_amag;
            r_d1mag <= n_d1mag;
            r_side_b <= r_side_a;
            for (int l = 0; l < NL; l++) begin
                r_prod[l] <= r_amag[sbit_pkg::oth((l / 2) % 3, l % 2)] * r_d1mag[l / 2];
                r_div[l] <= r_amag[(l / 2) % 3];
            end
        end
    end

    assign o_valid = r_vb;
    assign o_prod = r_prod;
    assign o_div = r_div;
    assign o_side = r_side_b;
endmodule

// ===== hdl/sbit_div.sv =====
// ============================================================================
// sbit_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
`timescale 1ns / 1ps

module sbit_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [2*sbit_pkg::CW-1:0]     i_prod,
    input  logic [sbit_pkg::CW-1:0]       i_div,
    output logic [sbit_pkg::CW-1:0]       o_quo
);
    localparam int CW = sbit_pkg::CW;

    logic [CW-1:0] r_rem [CW];
    logic [CW-1:0] r_low [CW];
    logic [CW-1:0] r_q   [CW];
    logic [CW-1:0] r_d   [CW];

    for (genvar i = 0; i < CW; i++) begin : g_stage
        logic [CW-1:0] rem_in, low_in, q_in, d_in;
        logic [CW:0] t, sub;
        logic ge;
        if (i == 0) begin : g_first
            assign rem_in = i_prod[2*CW-1:CW];
            assign low_in = i_prod[CW-1:0];
            assign q_in = '0;
            assign d_in = i_div;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign low_in = r_low[i-1];
            assign q_in = r_q[i-1];
            assign d_in = r_d[i-1];
        end
        assign t = {rem_in, low_in[CW-1]};
        assign sub = t - {1'b0, d_in};
        assign ge = t >= {1'b0, d_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= ge ? sub[CW-1:0] : t[CW-1:0];
                r_low[i] <= {low_in[CW-2:0], 1'b0};
                r_q[i] <= {q_in[CW-2:0], ge};
                r_d[i] <= d_in;
            end
        end
    end

    assign o_quo = r_q[CW-1];
endmodule

// ===== hdl/sbit_back.sv =====
// ============================================================================
// sbit_back
// Crossing points, face decisions and the output register with skid stage.
// ============================================================================
`timescale 1ns / 1ps

module sbit_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sbit_pkg::t_lanes   i_quo,
    input  sbit_pkg::t_side    i_side,
    output logic               o_en,
    sbit_out_if.source         o_out_word
);
    localparam int CW = sbit_pkg::CW;
    localparam int NL = sbit_pkg::NL;

    logic [NL-1:0] lane_in;
    logic hit;
    logic signed [CW+1:0] hv [NL];
    logic signed [CW+1:0] qv [NL];
    logic r_ov, r_sv, r_hit, r_skid_hit;
    logic n_ov, n_sv, n_hit, n_skid_hit;
    logic take;

    always_comb begin
        hit = i_side.start_in;
        for (int l = 0; l < NL; l++) begin
            qv[l] = $signed({2'b00, i_quo[l]});
            hv[l] = $signed({{2{i_side.s[sbit_pkg::oth((l / 2) % 3, l % 2)][CW-1]}},
                             i_side.s[sbit_pkg::oth((l / 2) % 3, l % 2)]}) +
                    (i_side.neg[l] ? -qv[l] : qv[l]);
            lane_in[l] =
                hv[l] > $signed({{2{i_side.lo[sbit_pkg::oth((l / 2) % 3, l % 2)][CW-1]}},
                                 i_side.lo[sbit_pkg::oth((l / 2) % 3, l % 2)]}) &&
                hv[l] < $signed({{2{i_side.hi[sbit_pkg::oth((l / 2) % 3, l % 2)][CW-1]}},
                                 i_side.hi[sbit_pkg::oth((l / 2) % 3, l % 2)]});
        end
        for (int f = 0; f < 6; f++) begin
            if (i_side.strad[f] && lane_in[2*f] && lane_in[2*f+1]) begin
                hit = 1'b1;
            end
        end
        if (i_side.reject) begin
            hit = 1'b0;
        end
    end

    assign o_en = !r_sv;
    assign take = i_valid && !r_sv;

    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        n_hit = r_hit;
        n_skid_hit = r_skid_hit;
        if (r_ov && !o_out_word.ready) begin
            if (take) begin
                n_sv = 1'b1;
                n_skid_hit = hit;
            end
        end else if (r_sv) begin
            n_ov = 1'b1;
            n_hit = r_skid_hit;
            n_sv = 1'b0;
        end else begin
            n_ov = take;
            n_hit = hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
        r_hit <= n_hit;
        r_skid_hit <= n_skid_hit;
    end

    assign o_out_word.valid = r_ov;
    assign o_out_word.hit = r_hit;
endmodule

// ===== hdl/segment_box_intersection_test.sv =====
// ============================================================================
// segment_box_intersection_test
// Tests a line segment against an axis-aligned box, one query per cycle when not stalled.
// ============================================================================
// The query channel i_in_word carries both segment endpoints and the box
// corners as signed Q16.16 values; the result channel o_out_word carries one
// hit flag per query, in query order. A word moves when valid and ready are
// both high.
// The accepting edge loads the first of two front stages for distances and
// the twelve products, then come 32 divider stages that produce one quotient
// bit each, and the output register that drives o_out_word. Throughput is
// one query per cycle while the receiver keeps taking result words.
// Reset clears all valid bits; no result words appear after reset until
// queries arrive.
// When the receiver stalls, the pending result sits in the output register
// and the next one drops into a skid stage; only when that is full does the
// pipeline freeze and the query channel drop ready.
// ============================================================================
`timescale 1ns / 1ps

module segment_box_intersection_test (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbit_in_if.sink    i_in_word,
    sbit_out_if.source o_out_word
);
    localparam int CW = sbit_pkg::CW;
    localparam int NL = sbit_pkg::NL;

    logic             en;
    logic             f_valid;
    sbit_pkg::t_prods f_prod;
    sbit_pkg::t_lanes f_div;
    sbit_pkg::t_side  f_side;
    sbit_pkg::t_lanes quo;

    logic            r_v    [CW];
    sbit_pkg::t_side r_side [CW];

    assign i_in_word.ready = en;

    sbit_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_in_word (i_in_word),
        .o_valid   (f_valid),
        .o_prod    (f_prod),
        .o_div     (f_div),
        .o_side    (f_side)
    );

    for (genvar l = 0; l < NL; l++) begin : g_lane
        sbit_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_prod (f_prod[l]),
            .i_div  (f_div[l]),
            .o_quo  (quo[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CW; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= f_valid;
            for (int i = 1; i < CW; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= f_side;
            for (int i = 1; i < CW; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    sbit_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v[CW-1]),
        .i_quo      (quo),
        .i_side     (r_side[CW-1]),
        .o_en       (en),
        .o_out_word (o_out_word)
    );
endmodule

// ===== hdl/sbit_checker.sv =====
// ============================================================================
// sbit_checker
// Port-level checks of the segment box test, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "segment_box_intersection_test_defines.svh"

module sbit_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_hit
);
    // A stalled result word keeps its flag.
    `SBIT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_hit))

    // The query channel only stalls while a result word is waiting.
    `SBIT_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // Once stalled with the receiver still blocked, the stall persists.
    `SBIT_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !i_in_ready && !i_out_ready, !i_in_ready)

    // Reset empties the pipeline.
    `SBIT_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid && i_in_ready)
endmodule

bind segment_box_intersection_test sbit_checker u_sbit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in_word.ready),
    .i_out_valid (o_out_word.valid),
    .i_out_ready (o_out_word.ready),
    .i_out_hit   (o_out_word.hit)
);
